// ----- design/pfse_pkg.sv -----
// ----------------------------------------------------------------------------
// pfse_pkg: shared definitions for the page frame buffer scroll engine
// Store geometry, opcode codes and the command and queue status types that
// pass between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package pfse_pkg;

	// Store geometry
	localparam int PAGES       = 8;
	localparam int COLUMNS     = 128;
	localparam int STORE_BYTES = PAGES * COLUMNS;
	localparam int MEM_AW      = $clog2(STORE_BYTES);
	localparam int COL_W       = $clog2(COLUMNS);
	localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;

	// Command queue depth
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Opcodes
	localparam logic [2:0] OP_CLEAR      = 3'd0;
	localparam logic [2:0] OP_FILL       = 3'd1;
	localparam logic [2:0] OP_SET_BIT    = 3'd2;
	localparam logic [2:0] OP_CLR_BIT    = 3'd3;
	localparam logic [2:0] OP_READ_BIT   = 3'd4;
	localparam logic [2:0] OP_READ_BYTE  = 3'd5;
	localparam logic [2:0] OP_WRITE_BYTE = 3'd6;
	localparam logic [2:0] OP_SCROLL     = 3'd7;

	// One classified command as held in the queue
	typedef struct packed {
		logic [2:0] op;
		logic [9:0] addr;
		logic [2:0] bit_sel;
		logic [7:0] wval;
		logic       in_range;
	} pfse_cmd_t;

	// Queue status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} pfse_qstat_t;

endpackage

// ----- design/pfse_front.sv -----
// ----------------------------------------------------------------------------
// pfse_front: command intake
// Accepts a command when start is high and busy is low, checks its address
// against the store size and pushes the classified command into the queue.
// ----------------------------------------------------------------------------
module pfse_front import pfse_pkg::*; (
	input  logic        start,
	input  logic [2:0]  opcode,
	input  logic [9:0]  byte_address,
	input  logic [2:0]  bit_index,
	input  logic [7:0]  write_value,
	input  pfse_qstat_t qstat,
	input  logic        init_busy,
	output logic        busy,
	output logic        push,
	output pfse_cmd_t   cmd
);

	// Hold off intake while the queue is full or the store is being cleared
	assign busy = qstat.full | init_busy;
	assign push = start & ~busy;

	// Classify: flag addresses that fall inside the store
	always_comb begin
		cmd.op       = opcode;
		cmd.addr     = byte_address;
		cmd.bit_sel  = bit_index;
		cmd.wval     = write_value;
		cmd.in_range = (32'(byte_address) < STORE_BYTES);
	end

endmodule

// ----- design/pfse_queue.sv -----
// ----------------------------------------------------------------------------
// pfse_queue: command queue
// Small register FIFO that decouples command intake from execution.
// ----------------------------------------------------------------------------
module pfse_queue import pfse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  pfse_cmd_t   push_data,
	input  logic        pop,
	output pfse_cmd_t   pop_data,
	output pfse_qstat_t qstat
);

	pfse_cmd_t           entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign qstat.full  = (count_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_data    = entry_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == QPTR_W'(QDEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == QPTR_W'(QDEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/pfse_back.sv -----
// ----------------------------------------------------------------------------
// pfse_back: command execution
// Owns the single-port frame store. Runs the clearing pass after reset,
// sweeps for clear and fill, does read-modify-write for pixel commands and
// walks each column bottom up for the one-pixel scroll. Issues one result
// strobe per command.
// ----------------------------------------------------------------------------
module pfse_back import pfse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pfse_qstat_t qstat,
	input  pfse_cmd_t   q_data,
	output logic        q_pop,
	output logic        init_busy,
	output logic        done,
	output logic [7:0]  read_value
);

	localparam logic [3:0] ST_INIT   = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_SWEEP  = 4'd2;
	localparam logic [3:0] ST_RD     = 4'd3;
	localparam logic [3:0] ST_MOD    = 4'd4;
	localparam logic [3:0] ST_RESP   = 4'd5;
	localparam logic [3:0] ST_WR     = 4'd6;
	localparam logic [3:0] ST_SCR_RD = 4'd7;
	localparam logic [3:0] ST_SCR_WR = 4'd8;

	localparam logic [MEM_AW-1:0] LAST_ADDR = MEM_AW'(STORE_BYTES - 1);
	localparam logic [MEM_AW-1:0] LAST_BASE = MEM_AW'((PAGES - 1) * COLUMNS);
	localparam logic [MEM_AW-1:0] COL_STEP  = MEM_AW'(COLUMNS);

	logic [7:0]        mem [STORE_BYTES];
	logic [7:0]        rd_q;
	logic              mem_we;
	logic [7:0]        mem_wdata;

	logic [3:0]        state_q;
	logic [MEM_AW-1:0] addr_q;
	logic [2:0]        op_q;
	logic [2:0]        bit_q;
	logic [7:0]        wval_q;
	logic [7:0]        fill_q;
	logic [COL_W-1:0]  col_q;
	logic [PAGE_W-1:0] page_q;
	logic              carry_q;
	logic              done_q;
	logic [7:0]        result_q;
	logic [7:0]        mask;

	assign mask       = 8'b1 << bit_q;
	assign q_pop      = (state_q == ST_IDLE) && !qstat.empty;
	assign init_busy  = (state_q == ST_INIT);
	assign done       = done_q;
	assign read_value = result_q;

	// Select write data for the store
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = 8'h00;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_wdata = fill_q;
			end
			ST_MOD: begin
				mem_we    = 1'b1;
				mem_wdata = (op_q == OP_SET_BIT) ? (rd_q | mask) : (rd_q & ~mask);
			end
			ST_WR: begin
				mem_we    = 1'b1;
				mem_wdata = wval_q;
			end
			ST_SCR_WR: begin
				mem_we    = 1'b1;
				mem_wdata = {carry_q, rd_q[7:1]};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Frame store: one registered read per cycle, plus a write when mem_we is set, both at addr_q
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= mem_wdata;
		end
		rd_q <= mem[addr_q];
	end

	// Sequence commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			addr_q   <= '0;
			op_q     <= OP_CLEAR;
			bit_q    <= '0;
			wval_q   <= '0;
			fill_q   <= '0;
			col_q    <= '0;
			page_q   <= '0;
			carry_q  <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (!qstat.empty) begin
						op_q   <= q_data.op;
						bit_q  <= q_data.bit_sel;
						wval_q <= q_data.wval;
						case (q_data.op)
							OP_CLEAR, OP_FILL: begin
								fill_q  <= (q_data.op == OP_FILL) ? 8'hFF : 8'h00;
								addr_q  <= '0;
								state_q <= ST_SWEEP;
							end
							OP_SCROLL: begin
								col_q   <= '0;
								page_q  <= PAGE_W'(PAGES - 1);
								addr_q  <= LAST_BASE;
								carry_q <= 1'b0;
								state_q <= ST_SCR_RD;
							end
							default: begin
								if (q_data.in_range) begin
									addr_q  <= MEM_AW'(q_data.addr);
									state_q <= (q_data.op == OP_WRITE_BYTE) ? ST_WR : ST_RD;
								end else begin
									// Drop out-of-range pixel commands, answer zero
									done_q   <= 1'b1;
									result_q <= '0;
								end
							end
						endcase
					end
				end
				ST_SWEEP: begin
					if (addr_q == LAST_ADDR) begin
						done_q   <= 1'b1;
						result_q <= '0;
						state_q  <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_RD: begin
					if (op_q == OP_SET_BIT || op_q == OP_CLR_BIT) begin
						state_q <= ST_MOD;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_MOD, ST_WR: begin
					done_q   <= 1'b1;
					result_q <= '0;
					state_q  <= ST_IDLE;
				end
				ST_RESP: begin
					done_q   <= 1'b1;
					result_q <= (op_q == OP_READ_BIT) ? {7'b0, rd_q[bit_q]} : rd_q;
					state_q  <= ST_IDLE;
				end
				ST_SCR_RD: begin
					state_q <= ST_SCR_WR;
				end
				ST_SCR_WR: begin
					// Carry bit 0 of the old byte up into the page above
					carry_q <= rd_q[0];
					state_q <= ST_SCR_RD;
					if (page_q == '0) begin
						carry_q <= 1'b0;
						if (col_q == COL_W'(COLUMNS - 1)) begin
							done_q   <= 1'b1;
							result_q <= '0;
							state_q  <= ST_IDLE;
						end else begin
							col_q  <= col_q + 1'b1;
							page_q <= PAGE_W'(PAGES - 1);
							addr_q <= LAST_BASE + MEM_AW'(col_q) + 1'b1;
						end
					end else begin
						page_q <= page_q - 1'b1;
						addr_q <= addr_q - COL_STEP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/page_framebuffer_pixel_scroll_engine.sv -----
// Byte writes go from the queue straight to a store write; pixel set/clear read,
// then modify and write back; reads read, then respond. Clear and fill sweep the store;
// scroll reads and writes each byte (single-port store). Out-of-range commands skip it.
// A 2-entry command queue absorbs intake while the back end works.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset: async, active low; a clearing pass follows with busy held high.
// ----------------------------------------------------------------------------
// page_framebuffer_pixel_scroll_engine: top level
// Monochrome paged frame store with pixel access, byte access, clear, fill
// and one-pixel vertical scroll. Front end, command queue and back end.
// ----------------------------------------------------------------------------
module page_framebuffer_pixel_scroll_engine import pfse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] opcode,
	input  logic [9:0] byte_address,
	input  logic [2:0] bit_index,
	input  logic [7:0] write_value,
	output logic       done,
	output logic [7:0] read_value
);

	pfse_qstat_t qstat;
	pfse_cmd_t   push_cmd;
	pfse_cmd_t   pop_cmd;
	logic        push;
	logic        pop;
	logic        init_busy;

	pfse_front u_front (
		.start        (start),
		.opcode       (opcode),
		.byte_address (byte_address),
		.bit_index    (bit_index),
		.write_value  (write_value),
		.qstat        (qstat),
		.init_busy    (init_busy),
		.busy         (busy),
		.push         (push),
		.cmd          (push_cmd)
	);

	pfse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.pop_data  (pop_cmd),
		.qstat     (qstat)
	);

	pfse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.q_data     (pop_cmd),
		.q_pop      (pop),
		.init_busy  (init_busy),
		.done       (done),
		.read_value (read_value)
	);

`ifndef SYNTHESIS
	// No result while the clearing pass runs
	a_no_done_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !done)
		else $error("result strobe during clearing pass");

	// Nothing is queued during the clearing pass
	a_empty_after_init: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(init_busy) |-> qstat.empty)
		else $error("command queued during clearing pass");

	// An accepted command is held in the queue on the next cycle
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !qstat.empty)
		else $error("accepted command lost");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for page_framebuffer_pixel_scroll_engine
// A queue of commands, directed first and random after, feeds a clocked
// driver. Each transfer also runs on a shadow copy of the frame store to give
// the expected read_value. A clocked monitor checks every done strobe
// against the oldest expected value.
// ----------------------------------------------------------------------------
module tb;
	import pfse_pkg::*;

	typedef struct {
		logic [2:0]  op;
		logic [9:0]  addr;
		logic [2:0]  bsel;
		logic [7:0]  wval;
		int unsigned gap;
		bit          drain;
	} fb_cmd_t;

	typedef struct {
		logic [2:0] op;
		logic [9:0] addr;
		logic [7:0] value;
	} fb_read_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] opcode;
	logic [9:0] byte_address;
	logic [2:0] bit_index;
	logic [7:0] write_value;
	logic       done;
	logic [7:0] read_value;

	fb_cmd_t     cmd_queue[$];
	fb_read_t    read_queue[$];
	logic [7:0]  shadow_fb [STORE_BYTES];
	int unsigned gap_left       = 0;
	int unsigned sent_count     = 0;
	int unsigned seen_count     = 0;
	int unsigned mismatch_count = 0;

	page_framebuffer_pixel_scroll_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.byte_address (byte_address),
		.bit_index    (bit_index),
		.write_value  (write_value),
		.done         (done),
		.read_value   (read_value)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one command to the shadow store and return the value it reads
	function automatic logic [7:0] shadow_execute(fb_cmd_t c);
		logic [7:0] mask;
		logic [7:0] shifted;
		logic       in_store;
		logic [7:0] rd;
		mask     = 8'd1 << c.bsel;
		in_store = (c.addr < STORE_BYTES);
		rd       = 8'h00;
		case (c.op)
			OP_CLEAR: begin
				foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
			end
			OP_FILL: begin
				foreach (shadow_fb[i]) shadow_fb[i] = 8'hFF;
			end
			OP_SET_BIT: begin
				if (in_store) shadow_fb[c.addr] = shadow_fb[c.addr] | mask;
			end
			OP_CLR_BIT: begin
				if (in_store) shadow_fb[c.addr] = shadow_fb[c.addr] & ~mask;
			end
			OP_READ_BIT: begin
				if (in_store) rd = ((shadow_fb[c.addr] & mask) != 8'h00) ? 8'd1 : 8'd0;
			end
			OP_READ_BYTE: begin
				if (in_store) rd = shadow_fb[c.addr];
			end
			OP_WRITE_BYTE: begin
				if (in_store) shadow_fb[c.addr] = c.wval;
			end
			OP_SCROLL: begin
				// ascending walk: the byte below is read before it is shifted
				for (int i = 0; i < STORE_BYTES; i++) begin
					shifted = shadow_fb[i] >> 1;
					if (i + COLUMNS < STORE_BYTES) shifted[7] = shadow_fb[i + COLUMNS][0];
					shadow_fb[i] = shifted;
				end
			end
			default: begin
				rd = 8'h00;
			end
		endcase
		return rd;
	endfunction

	task automatic push_cmd(logic [2:0] op, logic [9:0] addr, logic [2:0] bsel,
			logic [7:0] wval, int unsigned gap, bit drain);
		fb_cmd_t c;
		c.op    = op;
		c.addr  = addr;
		c.bsel  = bsel;
		c.wval  = wval;
		c.gap   = gap;
		c.drain = drain;
		cmd_queue.push_back(c);
	endtask

	function automatic void log_fault(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("mismatch: %s", msg);
	endfunction

	// Driver: present the head command, pop it on transfer, idle between items
	always @(posedge clk or negedge arst_n) begin : cmd_drive
		fb_cmd_t  nxt;
		fb_read_t want;
		if (!arst_n) begin
			start        <= 1'b0;
			opcode       <= OP_CLEAR;
			byte_address <= '0;
			bit_index    <= '0;
			write_value  <= '0;
			gap_left     = 0;
			sent_count   = 0;
			seen_count   = 0;
		end else begin
			if (done) seen_count++;
			// transfer: predict and queue the expected value
			if (start && !busy) begin
				nxt        = cmd_queue.pop_front();
				want.op    = nxt.op;
				want.addr  = nxt.addr;
				want.value = shadow_execute(nxt);
				read_queue.push_back(want);
				sent_count++;
				gap_left = (cmd_queue.size() > 0) ? cmd_queue[0].gap : 0;
			end
			// hold while refused, else launch the next item or idle
			if (!(start && busy)) begin
				if (cmd_queue.size() > 0 && gap_left == 0
						&& !(cmd_queue[0].drain && sent_count != seen_count)) begin
					start        <= 1'b1;
					opcode       <= cmd_queue[0].op;
					byte_address <= cmd_queue[0].addr;
					bit_index    <= cmd_queue[0].bsel;
					write_value  <= cmd_queue[0].wval;
				end else begin
					start <= 1'b0;
					if (gap_left > 0) gap_left--;
				end
			end
		end
	end

	// Monitor: every done strobe carries one result
	always @(posedge clk) begin : result_check
		fb_read_t want;
		if (arst_n && done) begin
			if (read_queue.size() == 0) begin
				log_fault($sformatf("result with none pending, read_value=%02h", read_value));
			end else begin
				want = read_queue.pop_front();
				if (read_value !== want.value)
					log_fault($sformatf("op %0d addr %0d: expected read_value %02h, got %02h",
						want.op, want.addr, want.value, read_value));
			end
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		logic [2:0]  op;
		logic [9:0]  addr;
		logic [7:0]  wval;
		int unsigned pick;
		int unsigned gap;
		int unsigned col_sel;
		arst_n = 1'b0;
		foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;

		// directed: reset contents, edges of the store, scroll across pages
		push_cmd(OP_READ_BYTE,  10'd0,    3'd0, 8'h00, 0, 0);
		push_cmd(OP_READ_BIT,   10'd1023, 3'd7, 8'hFF, 0, 0);
		push_cmd(OP_WRITE_BYTE, 10'd0,    3'd0, 8'hA5, 1, 0);
		push_cmd(OP_WRITE_BYTE, 10'd128,  3'd7, 8'h01, 0, 0);
		push_cmd(OP_WRITE_BYTE, 10'd1023, 3'd0, 8'hFF, 2, 0);
		push_cmd(OP_WRITE_BYTE, 10'd896,  3'd3, 8'h81, 0, 0);
		push_cmd(OP_SET_BIT,    10'd5,    3'd0, 8'h00, 0, 0);
		push_cmd(OP_SET_BIT,    10'd5,    3'd7, 8'hFF, 3, 0);
		push_cmd(OP_CLR_BIT,    10'd0,    3'd0, 8'h00, 0, 0);
		push_cmd(OP_READ_BIT,   10'd5,    3'd7, 8'h00, 0, 0);
		push_cmd(OP_READ_BIT,   10'd0,    3'd0, 8'hFF, 1, 0);
		push_cmd(OP_READ_BYTE,  10'd0,    3'd5, 8'h00, 0, 0);
		push_cmd(OP_SCROLL,     10'd1023, 3'd7, 8'hFF, 0, 0);
		push_cmd(OP_READ_BYTE,  10'd0,    3'd0, 8'h00, 0, 0);
		push_cmd(OP_READ_BYTE,  10'd1023, 3'd0, 8'h00, 0, 0);
		push_cmd(OP_READ_BYTE,  10'd768,  3'd0, 8'h00, 2, 0);
		push_cmd(OP_FILL,       10'd0,    3'd0, 8'h00, 0, 0);
		push_cmd(OP_READ_BYTE,  10'd1023, 3'd2, 8'h5A, 0, 0);
		push_cmd(OP_CLR_BIT,    10'd1023, 3'd7, 8'h00, 0, 0);
		push_cmd(OP_SCROLL,     10'd0,    3'd0, 8'h00, 1, 0);
		push_cmd(OP_READ_BYTE,  10'd1023, 3'd0, 8'h00, 0, 0);
		push_cmd(OP_READ_BYTE,  10'd895,  3'd0, 8'h00, 0, 0);
		push_cmd(OP_CLEAR,      10'd1023, 3'd7, 8'hFF, 0, 0);
		push_cmd(OP_READ_BIT,   10'd512,  3'd3, 8'h00, 0, 0);
		push_cmd(OP_READ_BYTE,  10'd0,    3'd0, 8'h00, 0, 0);

		// random: mostly pixel traffic on a hot set of edge columns, rare bulk ops
		for (int n = 0; n < 1950; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 2)      op = OP_CLEAR;
			else if (pick < 4) op = OP_FILL;
			else if (pick < 7) op = OP_SCROLL;
			else               op = OP_SET_BIT + 3'($urandom_range(0, 4));

			if ($urandom_range(0, 1) == 0) begin
				col_sel = $urandom_range(0, 7);
				col_sel = (col_sel < 4) ? col_sel : COLUMNS - 8 + col_sel;
				addr    = 10'($urandom_range(0, PAGES - 1) * COLUMNS + col_sel);
			end else begin
				addr = 10'($urandom_range(0, 1023));
			end

			pick = $urandom_range(0, 99);
			if (pick < 8)       wval = 8'h00;
			else if (pick < 16) wval = 8'hFF;
			else if (pick < 20) wval = 8'h01;
			else if (pick < 24) wval = 8'h80;
			else                wval = 8'($urandom_range(0, 255));

			// bursts with no idling, elsewhere mostly short gaps and a few long ones
			if ((n / 80) % 3 == 0) begin
				gap = 0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 55)      gap = 0;
				else if (pick < 85) gap = $urandom_range(1, 3);
				else if (pick < 97) gap = $urandom_range(4, 12);
				else                gap = $urandom_range(20, 80);
			end

			push_cmd(op, addr, 3'($urandom_range(0, 7)), wval, gap, (n % 400) == 0);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all transfers done, all results in, then a short tail
		while (cmd_queue.size() != 0 || start) @(negedge clk);
		while (read_queue.size() != 0) @(negedge clk);
		repeat (16) @(negedge clk);

		if (mismatch_count == 0 && read_queue.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#200_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
design/pfse_pkg.sv
design/pfse_front.sv
design/pfse_queue.sv
design/pfse_back.sv
design/page_framebuffer_pixel_scroll_engine.sv
tb/tb.sv
